/* rtl/core/assert_macros.svh */
// Assertion macros shared by the deque RTL; clock and reset are taken from the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define BDQ_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("bdq assertion failed");

// Check that a trigger implies a consequence in the same cycle.
`define BDQ_ASSERT_IMPLY(label, trig, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cons)) \
      else $error("bdq assertion failed");

`endif

/* rtl/core/bdq_pkg.sv */
// Package with opcodes, status codes, word widths and the memory enable struct.
package bdq_pkg;

   localparam int OPCODE_W = 3;
   localparam int STATUS_W = 3;
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = 5;

   // Operation codes
   localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_SEARCH     = 3'd4;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

   // Memory port enables
   typedef struct packed {
      logic wr;
      logic rd;
   } ram_en_type;

endpackage

/* rtl/core/bdq_ram.sv */
// Entry store: one write port, one read port with registered read data.
module bdq_ram
   import bdq_pkg::*;
#(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic               clock,
   input  ram_en_type         ram_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [VALUE_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [VALUE_W-1:0] rd_data
);

   logic [VALUE_W-1:0] mem_ff [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   // Write the word at the write address
   always_ff @(posedge clock) begin
      if (ram_en.wr) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read; hold the word while no read is issued
   always_ff @(posedge clock) begin
      if (ram_en.rd) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/bounded_deque_with_search.sv */
// Bounded double-ended queue of signed words in a ring memory, with a linear search.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/ready    req_opcode, req_operand_value
//   rsp      out        rsp_valid/ready    rsp_status, rsp_result_value, rsp_count_after
//
// Push and pop: the memory read is issued at accept; the execute state then updates
// the ring and loads the output register once the output register is free.
// Search reads the entries from the front toward the back, at most the count, and
// stops at the first match; one memory read per entry through the single read port.
// Reset clears the indexes, the count and the output valid; memory contents stay.
// A held output word stalls completion of the next word but not its accept.
`include "assert_macros.svh"

module bounded_deque_with_search
   import bdq_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [OPCODE_W-1:0]       req_opcode,
   input  logic signed [VALUE_W-1:0] req_operand_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic signed [VALUE_W-1:0] rsp_result_value,
   output logic [COUNT_W-1:0]        rsp_count_after
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

   // Controller states
   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic                 state_ff, state_in;
   logic [IDX_W-1:0]     front_ff, front_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     pos_ff, pos_in;
   logic [OPCODE_W-1:0]  op_ff;
   logic [VALUE_W-1:0]   val_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [VALUE_W-1:0]   rsp_value_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;

   ram_en_type           ram_en;
   logic [IDX_W-1:0]     rd_addr;
   logic [IDX_W-1:0]     wr_addr;
   logic [VALUE_W-1:0]   rd_data;

   logic                 accept;
   logic                 out_free;
   logic                 publish;
   logic [STATUS_W-1:0]  status;
   logic [VALUE_W-1:0]   result;
   logic [31:0]          count_wide;

   // Ring slot of the entry at a position counted from the front
   function automatic logic [IDX_W-1:0] slot_of(logic [IDX_W-1:0] base,
                                                logic [CNT_W-1:0] pos);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(base) + (CNT_W+1)'(pos);
      if (sum >= (CNT_W+1)'(CAPACITY)) begin
         sum = sum - (CNT_W+1)'(CAPACITY);
      end
      return sum[IDX_W-1:0];
   endfunction

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   bdq_ram #(
      .DEPTH  (CAPACITY),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .ram_en  (ram_en),
      .wr_addr (wr_addr),
      .wr_data (val_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // One request: read at accept, write on a push, read on for a search, then publish
   always_comb begin
      state_in = state_ff;
      front_in = front_ff;
      count_in = count_ff;
      pos_in   = pos_ff;
      ram_en   = '0;
      rd_addr  = front_ff;
      wr_addr  = front_ff;
      publish  = 1'b0;
      status   = ST_DONE;
      result   = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pos_in    = '0;
               ram_en.rd = 1'b1;
               state_in  = S_EXEC;
               if (req_opcode == OP_POP_BACK && count_ff != '0) begin
                  rd_addr = slot_of(front_ff, count_ff - CNT_W'(1));
               end
            end
         end
         S_EXEC: begin
            if (out_free) begin
               case (op_ff)
                  OP_PUSH_FRONT: begin
                     publish = 1'b1;
                     if (count_ff == FULL_CNT) begin
                        status = ST_FULL;
                     end else begin
                        wr_addr   = (front_ff == '0) ? LAST_IDX : front_ff - IDX_W'(1);
                        ram_en.wr = 1'b1;
                        front_in  = wr_addr;
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  OP_PUSH_BACK: begin
                     publish = 1'b1;
                     if (count_ff == FULL_CNT) begin
                        status = ST_FULL;
                     end else begin
                        wr_addr   = slot_of(front_ff, count_ff);
                        ram_en.wr = 1'b1;
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  OP_POP_FRONT: begin
                     publish = 1'b1;
                     if (count_ff == '0) begin
                        status = ST_EMPTY;
                     end else begin
                        result   = rd_data;
                        front_in = (front_ff == LAST_IDX) ? '0 : front_ff + IDX_W'(1);
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  OP_POP_BACK: begin
                     publish = 1'b1;
                     if (count_ff == '0) begin
                        status = ST_EMPTY;
                     end else begin
                        result   = rd_data;
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  OP_SEARCH: begin
                     result = val_ff;
                     if (count_ff == '0) begin
                        publish = 1'b1;
                        status  = ST_NOT_FOUND;
                     end else if (rd_data == val_ff) begin
                        publish = 1'b1;
                        status  = ST_FOUND;
                     end else if (pos_ff + CNT_W'(1) == count_ff) begin
                        publish = 1'b1;
                        status  = ST_NOT_FOUND;
                     end else begin
                        // advance to the next entry toward the back
                        pos_in    = pos_ff + CNT_W'(1);
                        rd_addr   = slot_of(front_ff, pos_in);
                        ram_en.rd = 1'b1;
                     end
                  end
                  default: begin
                     publish = 1'b1;
                  end
               endcase
               if (publish) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold the output word until taken; load a new one on publish
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign count_wide = 32'(count_in);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_opcode;
         val_ff <= req_operand_value;
      end
      if (publish) begin
         rsp_status_ff <= status;
         rsp_value_ff  <= result;
         rsp_count_ff  <= count_wide[COUNT_W-1:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_count_after  = rsp_count_ff;

   `BDQ_ASSERT_ALWAYS(a_count_bound, count_ff <= FULL_CNT)
   `BDQ_ASSERT_ALWAYS(a_front_bound, 32'(front_ff) < 32'(CAPACITY))
   `BDQ_ASSERT_IMPLY(a_write_not_full, ram_en.wr, state_ff == S_EXEC && count_ff != FULL_CNT)
   `BDQ_ASSERT_IMPLY(a_search_in_range, state_ff == S_EXEC && op_ff == OP_SEARCH && count_ff != '0,
                     pos_ff < count_ff)

endmodule
